FILE: src/tst_pkg.sv
// package for the segment time unit: sizes, register indexes and shared types
`timescale 1ns / 1ps
package tst_pkg;
    localparam int unsigned MaxSegmentsDefault = 256;
    localparam logic [31:0] MaxSpeedReset = 32'd655360;
    localparam logic [31:0] MaxAccelReset = 32'd262144;
    localparam logic [1:0] RegMaxSpeed   = 2'd0;
    localparam logic [1:0] RegMaxAccel   = 2'd1;
    localparam logic [1:0] RegStartSpeed = 2'd2;

    // datapath operations sequenced by the controller
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_SQR   = 3'd1,   // square and accumulate one axis
        OP_SQRT  = 3'd2,   // one bit of the distance root
        OP_CMP   = 3'd3,   // profile select products
        OP_QSTEP = 3'd4,   // one bit of the time search
        OP_LOAD  = 3'd5,   // latch inputs and differences
        OP_PREP  = 3'd6    // set up bound and divisor
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;   // axis for square, or sub-step of compare
        logic [5:0] bitn;   // bit under trial
        logic       mulph;  // second half of a two-phase trial
    } t_cmd;

    typedef struct packed {
        logic tri_mode;
    } t_sts;
endpackage

FILE: src/trapezoid_segment_time_unit.sv
// top level of the trapezoid segment time unit: registers, controller and datapath
`timescale 1ns / 1ps
// Takes 3-D waypoints one beat at a time and returns one segment time per
// segment (none for the first point of a run). For each later point, the
// block squares the axes, finds the two-phase distance root, picks the
// profile, sets up the bound, runs the two-phase bitwise time search and
// loads the output register. The root and the time search use shifted adds
// only. The next point of a run is taken once the previous result beat has
// left the output register. Configuration writes must go on the plain write
// port while the block is idle; the block itself does not enforce this.
module trapezoid_segment_time_unit
    import tst_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic        i_last_point,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_segment_time,
    output logic [7:0]  o_segment_index,
    output logic        o_last_segment
);
    logic [31:0] r_max_speed, r_max_accel, r_start_speed;
    t_cmd cmd;
    t_sts sts;
    logic first_seg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MaxSpeedReset;
            r_max_accel <= MaxAccelReset;
            r_start_speed <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegMaxSpeed:   r_max_speed <= i_cfg_data;
                RegMaxAccel:   r_max_accel <= i_cfg_data;
                RegStartSpeed: r_start_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tst_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_last_point, .o_valid, .i_stall,
        .o_segment_index, .o_last_segment, .o_first_seg(first_seg),
        .o_cmd(cmd), .i_sts(sts)
    );

    tst_datapath u_dp (
        .i_clk, .i_cmd(cmd), .i_pos_x, .i_pos_y, .i_pos_z,
        .i_max_speed(r_max_speed), .i_max_accel(r_max_accel),
        .i_start_speed(r_start_speed), .i_first_seg(first_seg),
        .o_sts(sts), .o_time(o_segment_time)
    );

    // a stalled result beat stays put
    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_segment_time) &&
        $stable(o_segment_index) && $stable(o_last_segment)))
        else $error("stalled result changed");
    // a new result beat is raised only from the busy state, with o_stall high
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)) else $error("result without work");
endmodule

FILE: src/tst_datapath.sv
// segment time datapath: differences, root, profile select and bitwise time search
`timescale 1ns / 1ps
module tst_datapath
    import tst_pkg::*;
(
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_max_speed,
    input  logic [31:0] i_max_accel,
    input  logic [31:0] i_start_speed,
    input  logic        i_first_seg,
    output t_sts        o_sts,
    output logic [31:0] o_time
);
    logic [31:0] r_px, r_py, r_pz;
    logic [32:0] r_dx, r_dy, r_dz;
    logic [67:0] r_acc;      // squared distance
    logic [34:0] r_root;
    logic [67:0] r_rr;       // square of the root so far
    logic [97:0] r_prod;     // registered trial value
    logic [83:0] r_bound;
    logic [66:0] r_k;        // divisor for linear searches
    logic [97:0] r_base;     // q*k, or t*t*a for the triangle
    logic [63:0] r_ta;       // t*a for the triangle
    logic [31:0] r_q;
    logic        r_tri;
    logic [67:0] r_vv;
    logic [67:0] r_da;

    function automatic logic [33:0] absd(input logic [31:0] a, input logic [31:0] b);
        logic signed [33:0] d;
        d = 34'($signed(a)) - 34'($signed(b));
        return d[33] ? 34'(-d) : d;
    endfunction

    logic [32:0] sel_d;
    logic [34:0] root_c;
    logic [31:0] q_c;
    logic        tri_search;
    logic [70:0] root_trial;
    logic [97:0] q_trial;
    always_comb begin
        case (i_cmd.axis)
            2'd0:    sel_d = r_dx;
            2'd1:    sel_d = r_dy;
            default: sel_d = r_dz;
        endcase
        root_c = r_root | (35'd1 << i_cmd.bitn);
        q_c = r_q | (32'd1 << i_cmd.bitn[4:0]);
        tri_search = (i_start_speed == 32'd0) && r_tri;
        // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
        root_trial = 71'(r_rr) + (71'(r_root) << (i_cmd.bitn + 6'd1))
                   + (71'd1 << {i_cmd.bitn, 1'b0});
        // triangle: (t + 2^b)^2*a = t*t*a + t*a*2^(b+1) + a*2^(2b)
        if (tri_search)
            q_trial = r_base + (98'(r_ta) << (i_cmd.bitn[4:0] + 6'd1))
                    + (98'(i_max_accel) << {i_cmd.bitn[4:0], 1'b0});
        else
            q_trial = r_base + (98'(r_k) << i_cmd.bitn[4:0]);
    end

    // roots and quotients are found bit by bit with shifted adds only
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_dx <= 33'(absd(i_pos_x, r_px));
                r_dy <= 33'(absd(i_pos_y, r_py));
                r_dz <= 33'(absd(i_pos_z, r_pz));
                r_px <= i_pos_x;
                r_py <= i_pos_y;
                r_pz <= i_pos_z;
                r_acc <= '0;
                r_root <= '0;
                r_rr <= '0;
            end
            OP_SQR: begin
                r_acc <= r_acc + 68'(sel_d * sel_d);
            end
            OP_SQRT: begin
                if (!i_cmd.mulph) begin
                    r_prod <= 98'(root_trial);
                end else if (r_prod <= 98'(r_acc)) begin
                    r_root <= root_c;
                    r_rr <= r_prod[67:0];
                end
            end
            OP_CMP: begin
                if (i_cmd.axis == 2'd0) begin
                    r_vv <= 68'(i_max_speed * i_max_speed);
                    r_da <= 68'(r_root * i_max_accel);
                end else begin
                    r_tri <= r_da < r_vv;
                end
            end
            OP_PREP: begin
                r_base <= '0;
                r_ta <= '0;
                r_q <= '0;
                if (i_start_speed != 32'd0) begin
                    if (i_first_seg) begin
                        r_bound <= 84'({r_root, 16'd0});
                        r_k <= 67'(i_start_speed);
                    end else begin
                        r_bound <= (84'(r_root) * 84'd17) << 16;
                        r_k <= 67'({i_max_speed, 2'b00}) + 67'(i_max_speed);
                    end
                end else if (r_tri) begin
                    r_bound <= 84'({r_root[33:0], 34'd0});
                    r_k <= 67'(i_max_accel);
                end else begin
                    r_bound <= (84'(r_vv) + 84'(r_da)) << 16;
                    r_k <= 67'(i_max_accel * i_max_speed);
                end
            end
            OP_QSTEP: begin
                if (!i_cmd.mulph) begin
                    r_prod <= q_trial;
                end else if (r_prod <= 98'(r_bound)) begin
                    r_q <= q_c;
                    r_base <= r_prod;
                    r_ta <= r_ta + (64'(i_max_accel) << i_cmd.bitn[4:0]);
                end
            end
            default: ;
        endcase
    end

    assign o_sts.tri_mode = r_tri;
    assign o_time = r_q;
endmodule

FILE: src/tst_ctrl.sv
// segment time controller: handshakes, run state and datapath sequencing
`timescale 1ns / 1ps
module tst_ctrl
    import tst_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_last_point,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_segment_index,
    output logic        o_last_segment,
    output logic        o_first_seg,
    output t_cmd        o_cmd,
    input  t_sts        i_sts
);
    localparam int unsigned SegLimitI = (MAX_SEGMENTS - 1) < 255 ? MAX_SEGMENTS - 1 : 255;
    localparam logic [7:0] SegLimit = 8'(SegLimitI);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_SQR = 7'b0000010, S_SQRT = 7'b0000100,
        S_CMP = 7'b0001000, S_PREP = 7'b0010000, S_Q = 7'b0100000, S_OUT = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_bit, n_bit;
    logic       r_ph, n_ph;
    logic [1:0] r_ax, n_ax;
    logic       r_have, n_have;
    logic [7:0] r_cnt, n_cnt;
    logic       r_last, n_last;
    logic       acc;
    logic [7:0] r_idx;
    logic       r_ovalid, n_ovalid;

    assign o_stall = (r_state != S_IDLE) || (r_ovalid && r_have);
    assign acc = i_valid && !o_stall;

    always_comb begin
        n_state = r_state; n_bit = r_bit; n_ph = r_ph; n_ax = r_ax;
        n_have = r_have; n_cnt = r_cnt; n_last = r_last;
        n_ovalid = r_ovalid && i_stall;
        o_cmd = '{op: OP_NONE, axis: r_ax, bitn: r_bit, mulph: r_ph};
        case (r_state)
            S_IDLE: if (acc) begin
                o_cmd.op = OP_LOAD;
                n_last = i_last_point;
                if (!r_have) begin
                    n_have = !i_last_point; n_cnt = 8'd0;
                end else begin
                    n_state = S_SQR; n_ax = 2'd0;
                end
            end
            S_SQR: begin
                o_cmd.op = OP_SQR;
                n_ax = r_ax + 2'd1;
                if (r_ax == 2'd2) begin
                    n_state = S_SQRT; n_bit = 6'd34; n_ph = 1'b0;
                end
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_ph = !r_ph;
                if (r_ph) begin
                    if (r_bit == 6'd0) begin
                        n_state = S_CMP; n_ax = 2'd0;
                    end else n_bit = r_bit - 6'd1;
                end
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_ax = 2'd1;
                if (r_ax == 2'd1) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                n_state = S_Q; n_bit = 6'd31; n_ph = 1'b0;
            end
            S_Q: begin
                o_cmd.op = OP_QSTEP;
                n_ph = !r_ph;
                if (r_ph) begin
                    if (r_bit == 6'd0) n_state = S_OUT;
                    else n_bit = r_bit - 6'd1;
                end
            end
            S_OUT: if (!r_ovalid) begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
                if (r_last) begin
                    n_have = 1'b0; n_cnt = 8'd0;
                end else if (r_cnt < SegLimit) n_cnt = r_cnt + 8'd1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_have <= 1'b0; r_cnt <= 8'd0; r_ovalid <= 1'b0;
            r_bit <= '0; r_ph <= 1'b0; r_ax <= '0; r_last <= 1'b0;
        end else begin
            r_state <= n_state; r_have <= n_have; r_cnt <= n_cnt; r_ovalid <= n_ovalid;
            r_bit <= n_bit; r_ph <= n_ph; r_ax <= n_ax; r_last <= n_last;
        end
        if (r_state == S_OUT && !r_ovalid) r_idx <= r_cnt;
    end

    logic r_olast;
    always_ff @(posedge i_clk) if (r_state == S_OUT && !r_ovalid) r_olast <= r_last;

    assign o_valid = r_ovalid;
    assign o_segment_index = r_idx;
    assign o_last_segment = r_olast;
    assign o_first_seg = (r_cnt == 8'd0);
    logic unused_tri;
    assign unused_tri = i_sts.tri_mode;
endmodule
